// ----- rtl/core/cms_pkg.sv -----
// Shared types and constants for the message serializer.
package cms_pkg;

    localparam int MAX_TOKEN_BYTES = 8;
    localparam int HEADER_BYTES    = 4;
    localparam int OPTION_BYTES    = 5;
    localparam int JOB_BYTES       = (HEADER_BYTES + MAX_TOKEN_BYTES > OPTION_BYTES) ?
                                     (HEADER_BYTES + MAX_TOKEN_BYTES) : OPTION_BYTES;
    localparam int CNT_W           = $clog2(JOB_BYTES + 1);
    localparam int IDX_W           = $clog2(JOB_BYTES);
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [15:0] EXT1_BASE = 16'd13;
    localparam logic [15:0] EXT2_BASE = 16'd269;
    localparam logic [3:0]  NIB_EXT1  = 4'd13;
    localparam logic [3:0]  NIB_EXT2  = 4'd14;

    typedef enum logic [1:0] {
        MODE_HEADER = 2'd0,
        MODE_OPTION = 2'd1,
        MODE_VALUE  = 2'd2,
        MODE_UNUSED = 2'd3
    } mode_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  version;
        logic [1:0]  msg_type;
        logic [3:0]  tok_len;
        logic [2:0]  req_class;
        logic [4:0]  req_detail;
        logic [15:0] message_id;
        logic [63:0] token;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic [7:0]  value_byte;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       order_error;
    } out_t;

    // One classified request: the bytes to send, how many, and the error mark.
    typedef struct packed {
        logic [JOB_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      err;
    } job_t;

endpackage

// ----- rtl/core/cms_front.sv -----
// Front end: accepts requests, tracks the option number and builds byte jobs.
module cms_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cms_pkg::in_t  in_data,
    output logic          job_valid,
    input  logic          job_ready,
    output cms_pkg::job_t job
);

    typedef struct packed {
        logic [3:0]  nib;
        logic [1:0]  ext;
        logic [15:0] val;
    } ext_t;

    function automatic ext_t nib_of(input logic [15:0] v);
        ext_t r;
        if (v < cms_pkg::EXT1_BASE) begin
            r.nib = v[3:0];
            r.ext = 2'd0;
            r.val = 16'd0;
        end
        else if (v < cms_pkg::EXT2_BASE) begin
            r.nib = cms_pkg::NIB_EXT1;
            r.ext = 2'd1;
            r.val = v - cms_pkg::EXT1_BASE;
        end
        else begin
            r.nib = cms_pkg::NIB_EXT2;
            r.ext = 2'd2;
            r.val = v - cms_pkg::EXT2_BASE;
        end
        return r;
    endfunction

    logic [15:0] prev_opt_reg;
    logic [15:0] prev_opt_next;
    logic        accept;
    logic        push;
    logic        descend;
    logic [15:0] delta;
    logic [3:0]  n_tok;
    logic [3:0]  sel;
    ext_t        d_enc;
    ext_t        l_enc;
    logic [1:0][7:0] d_seq;
    logic [1:0][7:0] l_seq;

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = in_valid && push;

    assign descend = in_data.option_number < prev_opt_reg;
    assign delta   = in_data.option_number - prev_opt_reg;
    assign d_enc   = nib_of(delta);
    assign l_enc   = nib_of(in_data.option_length);
    assign n_tok   = (in_data.tok_len > 4'(cms_pkg::MAX_TOKEN_BYTES)) ?
                     4'(cms_pkg::MAX_TOKEN_BYTES) : in_data.tok_len;

    // Extended bytes go out high byte first when two are needed.
    always_comb
    begin
        d_seq[0] = (d_enc.ext == 2'd2) ? d_enc.val[15:8] : d_enc.val[7:0];
        d_seq[1] = d_enc.val[7:0];
        l_seq[0] = (l_enc.ext == 2'd2) ? l_enc.val[15:8] : l_enc.val[7:0];
        l_seq[1] = l_enc.val[7:0];
    end

    always_comb
    begin
        job           = '0;
        push          = 1'b0;
        sel           = 4'd0;
        prev_opt_next = prev_opt_reg;
        unique case (in_data.mode)
            cms_pkg::MODE_HEADER:
            begin
                push          = 1'b1;
                prev_opt_next = 16'd0;
                job.bytes[0]  = {in_data.version, in_data.msg_type, in_data.tok_len};
                job.bytes[1]  = {in_data.req_class, in_data.req_detail};
                job.bytes[2]  = in_data.message_id[15:8];
                job.bytes[3]  = in_data.message_id[7:0];
                for (int i = 0; i < cms_pkg::MAX_TOKEN_BYTES; i++)
                begin
                    sel = n_tok - 4'(i) - 4'd1;
                    if (4'(i) < n_tok)
                    begin
                        job.bytes[cms_pkg::HEADER_BYTES + i] =
                            in_data.token[{sel[2:0], 3'b000} +: 8];
                    end
                end
                job.count = cms_pkg::CNT_W'(cms_pkg::HEADER_BYTES) + cms_pkg::CNT_W'(n_tok);
            end
            cms_pkg::MODE_OPTION:
            begin
                push = 1'b1;
                if (descend)
                begin
                    job.err   = 1'b1;
                    job.count = cms_pkg::CNT_W'(1);
                end
                else
                begin
                    prev_opt_next = in_data.option_number;
                    job.bytes[0]  = {d_enc.nib, l_enc.nib};
                    job.bytes[1]  = (d_enc.ext != 2'd0) ? d_seq[0] : l_seq[0];
                    job.bytes[2]  = (d_enc.ext == 2'd2) ? d_seq[1] :
                                    (d_enc.ext == 2'd1) ? l_seq[0] : l_seq[1];
                    job.bytes[3]  = (d_enc.ext == 2'd2) ? l_seq[0] :
                                    (d_enc.ext == 2'd1) ? l_seq[1] : 8'd0;
                    job.bytes[4]  = l_seq[1];
                    job.count     = cms_pkg::CNT_W'(1) + cms_pkg::CNT_W'(d_enc.ext)
                                  + cms_pkg::CNT_W'(l_enc.ext);
                end
            end
            cms_pkg::MODE_VALUE:
            begin
                push         = 1'b1;
                job.bytes[0] = in_data.value_byte;
                job.count    = cms_pkg::CNT_W'(1);
            end
            default:
            begin
                // unused mode: drop the request
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_opt_reg <= 16'd0;
        end
        else if (accept)
        begin
            prev_opt_reg <= prev_opt_next;
        end
    end

endmodule

// ----- rtl/core/cms_queue.sv -----
// Short job queue between front and back ends.
module cms_queue
#(
    parameter int DEPTH = cms_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  cms_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop_ready,
    output cms_pkg::job_t pop_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QC_W  = $clog2(DEPTH + 1);

    cms_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0]  count_reg;
    logic [QC_W-1:0]  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = count_reg != QC_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + QC_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - QC_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
        end
    end

endmodule

// ----- rtl/core/cms_back.sv -----
// Back end: walks the current job one byte per cycle into the output register while out_ready allows.
module cms_back
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  cms_pkg::job_t job,
    output logic          out_valid,
    input  logic          out_ready,
    output cms_pkg::out_t out_data
);

    cms_pkg::job_t             cur_reg;
    logic                      cur_valid_reg;
    logic [cms_pkg::CNT_W-1:0] idx_reg;
    cms_pkg::out_t             out_reg;
    logic                      out_valid_reg;
    logic                      emit;
    logic                      is_last;
    logic                      load;

    assign emit      = cur_valid_reg && (!out_valid_reg || out_ready);
    assign is_last   = idx_reg == (cur_reg.count - cms_pkg::CNT_W'(1));
    assign load      = !cur_valid_reg || (emit && is_last);
    assign job_ready = load;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk)
    begin
        if (load && job_valid)
        begin
            cur_reg <= job;
        end
        if (emit)
        begin
            out_reg.out_byte    <= cur_reg.bytes[idx_reg[cms_pkg::IDX_W-1:0]];
            out_reg.last_of_run <= is_last;
            out_reg.order_error <= cur_reg.err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load)
            begin
                cur_valid_reg <= job_valid;
                idx_reg       <= '0;
            end
            else if (emit)
            begin
                idx_reg <= idx_reg + cms_pkg::CNT_W'(1);
            end
        end
    end

`ifndef ASSERT_OFF
    a_job_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> cur_reg.count != '0)
        else $error("active job has no bytes");

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> idx_reg < cur_reg.count)
        else $error("byte index past end of job");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg && cur_reg.err |-> cur_reg.count == cms_pkg::CNT_W'(1))
        else $error("error job longer than one byte");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.order_error |-> out_reg.last_of_run)
        else $error("order error byte not marked last");
`endif

endmodule

// ----- rtl/core/coap_message_serializer_unit.sv -----
// Top level of the message serializer: front end, job queue and back end.
//
// Requests enter on in_valid/in_ready with an in_t payload; serialized bytes
// leave on out_valid/out_ready with an out_t payload, one byte per transfer.
// A header request yields four header bytes plus min(token length, 8) token
// bytes; an option-start request yields one to five bytes (delta/length byte,
// then extended delta, then extended length bytes); a value request yields its
// byte. A descending option number yields a single byte 0 with order_error
// and last_of_run set. last_of_run marks the final byte of every request.
// When the back end is free, the first byte of a request passes through the
// queue, the back end's job register and the output register. The back end
// emits one byte per cycle while the receiver does not stall; value requests
// then flow at one per cycle. The front end keeps accepting while the queue of
// QUEUE_DEPTH jobs has room, also while the receiver stalls.
// Reset clears the option number tracker, the queue and the back end's valid flags.
module coap_message_serializer_unit
#(
    parameter int QUEUE_DEPTH = cms_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  cms_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output cms_pkg::out_t out_data
);

    logic          f_valid;
    logic          f_ready;
    cms_pkg::job_t f_job;
    logic          b_valid;
    logic          b_ready;
    cms_pkg::job_t b_job;

    cms_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .job_valid (f_valid),
        .job_ready (f_ready),
        .job       (f_job)
    );

    cms_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_job   (f_job),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_job    (b_job)
    );

    cms_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (b_valid),
        .job_ready (b_ready),
        .job       (b_job),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ----- bench/coap_message_serializer_unit_tb.sv -----
// Self-checking testbench for the message serializer: directed table, then random messages.
module coap_message_serializer_unit_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int ITEM_TARGET  = 470;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_PRINTED  = 40;

    typedef struct {
        cms_pkg::in_t  req;
        bit            fixed;
        cms_pkg::out_t want;
    } stim_row_t;

    logic          clk;
    logic          rst_n;
    logic          in_valid;
    logic          in_ready;
    cms_pkg::in_t  in_data;
    logic          out_valid;
    logic          out_ready;
    cms_pkg::out_t out_data;

    cms_pkg::out_t expected_bytes[$];
    stim_row_t     directed_rows[$];
    logic [15:0]   prev_option;
    int            error_count = 0;
    int            cycle_count = 0;
    int            sent_items;
    int            rx_hold_len = 0;
    bit            tx_calm;
    bit            rx_calm;

    coap_message_serializer_unit u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED)
        begin
            $display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    function automatic void push_byte(input logic [7:0] b, input logic last, input logic err);
        cms_pkg::out_t r;
        r.out_byte    = b;
        r.last_of_run = last;
        r.order_error = err;
        expected_bytes.insert(expected_bytes.size(), r);
    endfunction

    // Delta or length nibble plus its extended bytes.
    function automatic logic [3:0] option_nibble(input logic [15:0] v, output int n_ext,
                                                 output logic [15:0] ext);
        if (v < cms_pkg::EXT1_BASE)
        begin
            n_ext = 0;
            ext   = '0;
            return v[3:0];
        end
        if (v < cms_pkg::EXT2_BASE)
        begin
            n_ext = 1;
            ext   = v - cms_pkg::EXT1_BASE;
            return cms_pkg::NIB_EXT1;
        end
        n_ext = 2;
        ext   = v - cms_pkg::EXT2_BASE;
        return cms_pkg::NIB_EXT2;
    endfunction

    function automatic void serialize_request(input cms_pkg::in_t req);
        logic [7:0]  run[$];
        logic [3:0]  dn;
        logic [3:0]  ln;
        logic [15:0] d_val;
        logic [15:0] l_val;
        int          d_ext;
        int          l_ext;
        int          n_tok;
        int          i;
        case (cms_pkg::mode_t'(req.mode))
            cms_pkg::MODE_HEADER:
            begin
                n_tok = (req.tok_len > cms_pkg::MAX_TOKEN_BYTES) ? cms_pkg::MAX_TOKEN_BYTES
                                                                : req.tok_len;
                push_byte({req.version, req.msg_type, req.tok_len}, 1'b0, 1'b0);
                push_byte({req.req_class, req.req_detail}, 1'b0, 1'b0);
                push_byte(req.message_id[15:8], 1'b0, 1'b0);
                push_byte(req.message_id[7:0], n_tok == 0, 1'b0);
                for (i = 0; i < n_tok; i++)
                begin
                    push_byte(req.token[8 * (n_tok - 1 - i) +: 8], i == n_tok - 1, 1'b0);
                end
                prev_option = '0;
            end
            cms_pkg::MODE_OPTION:
            begin
                if (req.option_number < prev_option)
                begin
                    push_byte(8'h00, 1'b1, 1'b1);
                end
                else
                begin
                    dn = option_nibble(req.option_number - prev_option, d_ext, d_val);
                    ln = option_nibble(req.option_length, l_ext, l_val);
                    run.insert(run.size(), {dn, ln});
                    if (d_ext == 2)
                        run.insert(run.size(), d_val[15:8]);
                    if (d_ext >= 1)
                        run.insert(run.size(), d_val[7:0]);
                    if (l_ext == 2)
                        run.insert(run.size(), l_val[15:8]);
                    if (l_ext >= 1)
                        run.insert(run.size(), l_val[7:0]);
                    for (i = 0; i < run.size(); i++)
                    begin
                        push_byte(run[i], i == run.size() - 1, 1'b0);
                    end
                    prev_option = req.option_number;
                end
            end
            cms_pkg::MODE_VALUE:
            begin
                push_byte(req.value_byte, 1'b1, 1'b0);
            end
            default:
            begin
            end
        endcase
    endfunction

    function automatic cms_pkg::in_t noise_req();
        cms_pkg::in_t r;
        r.mode          = 2'($urandom_range(0, 3));
        r.version       = 2'($urandom_range(0, 3));
        r.msg_type      = 2'($urandom_range(0, 3));
        r.tok_len       = 4'($urandom_range(0, 15));
        r.req_class     = 3'($urandom_range(0, 7));
        r.req_detail    = 5'($urandom_range(0, 31));
        r.message_id    = 16'($urandom_range(0, 16'hFFFF));
        r.token         = {$urandom, $urandom};
        r.option_number = 16'($urandom_range(0, 16'hFFFF));
        r.option_length = 16'($urandom_range(0, 16'hFFFF));
        r.value_byte    = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic cms_pkg::in_t header_req(input logic [1:0] ver, input logic [1:0] typ,
                                                input logic [3:0] tkl, input logic [2:0] cls,
                                                input logic [4:0] det, input logic [15:0] mid,
                                                input logic [63:0] tok);
        cms_pkg::in_t r;
        r            = noise_req();
        r.mode       = cms_pkg::MODE_HEADER;
        r.version    = ver;
        r.msg_type   = typ;
        r.tok_len    = tkl;
        r.req_class  = cls;
        r.req_detail = det;
        r.message_id = mid;
        r.token      = tok;
        return r;
    endfunction

    function automatic cms_pkg::in_t option_req(input logic [15:0] num,
                                                input logic [15:0] len);
        cms_pkg::in_t r;
        r               = noise_req();
        r.mode          = cms_pkg::MODE_OPTION;
        r.option_number = num;
        r.option_length = len;
        return r;
    endfunction

    function automatic cms_pkg::in_t value_req(input logic [7:0] b);
        cms_pkg::in_t r;
        r            = noise_req();
        r.mode       = cms_pkg::MODE_VALUE;
        r.value_byte = b;
        return r;
    endfunction

    function automatic void add_row(input cms_pkg::in_t req);
        stim_row_t row;
        row.req   = req;
        row.fixed = 1'b0;
        row.want  = '0;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Single-byte rows whose result is known by inspection.
    function automatic void add_fixed(input cms_pkg::in_t req, input logic [7:0] b,
                                      input logic err);
        stim_row_t row;
        row.req              = req;
        row.fixed            = 1'b1;
        row.want.out_byte    = b;
        row.want.last_of_run = 1'b1;
        row.want.order_error = err;
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer(input cms_pkg::in_t req, input bit fixed, input cms_pkg::out_t want);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do
            @(posedge clk);
        while (!in_ready);
        if (fixed)
            push_byte(want.out_byte, want.last_of_run, want.order_error);
        else
            serialize_request(req);
        if (req.mode != cms_pkg::MODE_UNUSED)
            sent_items++;
        @(negedge clk);
    endtask

    task automatic send_message();
        cms_pkg::in_t r;
        int           num;
        int           delta;
        int           room;
        int           len;
        int           n_val;
        int           pick;
        r         = noise_req();
        r.mode    = cms_pkg::MODE_HEADER;
        r.tok_len = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                   : $urandom_range(0, 8));
        offer(r, 1'b0, '0);
        num = 0;
        repeat ($urandom_range(0, 4))
        begin
            room = 65535 - num;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                delta = $urandom_range(0, 12);
            else if (pick < 8)
                delta = $urandom_range(13, 268);
            else
                delta = $urandom_range(269, 65535);
            if (delta > room)
                delta = $urandom_range(0, room);
            num += delta;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                len = $urandom_range(0, 12);
            else if (pick < 9)
                len = $urandom_range(13, 268);
            else
                len = $urandom_range(269, 65535);
            offer(option_req(16'(num), 16'(len)), 1'b0, '0);
            n_val = (len > 6) ? $urandom_range(0, 6) : len;
            repeat (n_val)
            begin
                offer(value_req(8'($urandom_range(0, 255))), 1'b0, '0);
            end
            // Break the order now and then.
            if (num > 0 && $urandom_range(0, 11) == 0)
                offer(option_req(16'($urandom_range(0, num - 1)),
                                 16'($urandom_range(0, 300))), 1'b0, '0);
        end
    endtask

    // Receiver: per-byte stall, plus one long hold when requested.
    initial
    begin
        int stall;
        bit hold_done;
        hold_done = 1'b0;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (rx_hold_len != 0 && !hold_done)
            begin
                stall     = rx_hold_len;
                hold_done = 1'b1;
            end
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin : check_output
        cms_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_bytes.size() == 0)
            begin
                report_mismatch("unexpected byte", out_data.out_byte, 8'd0);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_data.out_byte, want.out_byte);
                if (out_data.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run", 8'(out_data.last_of_run),
                                    8'(want.last_of_run));
                if (out_data.order_error !== want.order_error)
                    report_mismatch("order_error", 8'(out_data.order_error),
                                    8'(want.order_error));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int           k;
        cms_pkg::in_t spare;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        prev_option = '0;
        sent_items  = 0;
        tx_calm     = 1'b0;
        rx_calm     = 1'b0;

        add_fixed(option_req(16'd0, 16'd0), 8'h00, 1'b0);
        add_fixed(value_req(8'h00), 8'h00, 1'b0);
        add_fixed(value_req(8'hFF), 8'hFF, 1'b0);
        add_row(option_req(16'd12, 16'd12));
        add_row(option_req(16'd25, 16'd13));
        add_row(option_req(16'd293, 16'd268));
        add_row(option_req(16'd562, 16'd269));
        add_fixed(option_req(16'd100, 16'd5), 8'h00, 1'b1);
        add_row(option_req(16'hFFFF, 16'hFFFF));
        add_row(option_req(16'hFFFF, 16'd0));
        add_fixed(option_req(16'd0, 16'd1), 8'h00, 1'b1);
        spare      = noise_req();
        spare.mode = cms_pkg::MODE_UNUSED;
        add_row(spare);
        add_row(header_req(2'd3, 2'd3, 4'd0, 3'd7, 5'd31, 16'hFFFF, 64'h0));
        add_row(header_req(2'd0, 2'd0, 4'd8, 3'd0, 5'd0, 16'h0000, '1));
        add_row(header_req(2'd2, 2'd1, 4'd15, 3'd3, 5'd17, 16'h1234, 64'h0102030405060708));
        add_row(header_req(2'd1, 2'd0, 4'd1, 3'd2, 5'd5, 16'hA55A, 64'h00000000000000C3));
        add_row(option_req(16'hFFFF, 16'hFFFF));
        add_row(option_req(16'hFFFF, 16'd12));
        add_fixed(value_req(8'hA5), 8'hA5, 1'b0);
        add_row(header_req(2'd1, 2'd2, 4'd9, 3'd1, 5'd1, 16'h8001, 64'hFEDCBA9876543210));
        add_row(option_req(16'd268, 16'd268));
        add_row(option_req(16'd537, 16'd269));

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (k = 0; k < directed_rows.size(); k++)
        begin
            offer(directed_rows[k].req, directed_rows[k].fixed, directed_rows[k].want);
        end

        // Hold the sender until everything has drained.
        in_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);

        // Long receiver hold while the sender keeps pushing.
        rx_hold_len = LONG_HOLD;
        while (sent_items < ITEM_TARGET)
        begin
            if ($urandom_range(0, 7) == 0)
                tx_calm = !tx_calm;
            if ($urandom_range(0, 7) == 0)
                rx_calm = !rx_calm;
            if ($urandom_range(0, 9) < 8)
                send_message();
            else
                offer(noise_req(), 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
